### design/dis_pkg.sv
// Shared types and constants for the descending insertion sorter.
// Holds the controller state type and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package dis_pkg;

    // Default store depth
    localparam int DEF_CAPACITY = 64;

    // Width of one stored value and of the drop counter
    localparam int VALUE_W = 32;
    localparam int DROP_W  = 8;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_CMP,
        ST_EMIT_RD,
        ST_EMIT_LD,
        ST_EMIT_WAIT
    } state_t;

    // Store read address source
    typedef enum logic [1:0] {
        RD_POS_M1,
        RD_POS_M2,
        RD_EMIT
    } rd_src_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic    load_key;
        logic    drop_inc;
        logic    rd_en;
        rd_src_t rd_src;
        logic    wr_shift;
        logic    wr_key;
        logic    out_load;
        logic    clear;
    } dp_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic full;
        logic pos_zero;
        logic pos_one;
        logic shift_more;
        logic last_item;
        logic out_last;
    } dp_sts_t;

endpackage

`default_nettype wire

### design/dis_ctrl.sv
// Controller state machine for the descending insertion sorter.
// Sequences insertion walks and result emission; depends on dis_pkg.
`default_nettype none

module dis_ctrl
    import dis_pkg::*;
(
    input  wire     clk,
    input  wire     rst_n,
    input  wire     s_tvalid,
    input  wire     s_tlast,
    input  wire     m_tready,
    output logic    s_tready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_src = RD_POS_M1;
        s_tready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    if (sts.full)
                    begin
                        // Store full: drop the value, still honor the frame end
                        cmd.drop_inc = 1'b1;
                        if (s_tlast)
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        cmd.load_key = 1'b1;
                        state_next   = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                if (sts.pos_zero)
                begin
                    // Reached the head: place the key there
                    cmd.wr_key = 1'b1;
                    state_next = sts.last_item ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_src = RD_POS_M1;
                    state_next = ST_CMP;
                end
            end

            ST_CMP:
            begin
                if (sts.shift_more)
                begin
                    // Move the smaller entry down one slot, fetch the next one up
                    cmd.wr_shift = 1'b1;
                    if (sts.pos_one)
                    begin
                        state_next = ST_RD;
                    end
                    else
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_src = RD_POS_M2;
                    end
                end
                else
                begin
                    cmd.wr_key = 1'b1;
                    state_next = sts.last_item ? ST_EMIT_RD : ST_IDLE;
                end
            end

            ST_EMIT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_src = RD_EMIT;
                state_next = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                cmd.out_load = 1'b1;
                state_next   = ST_EMIT_WAIT;
            end

            ST_EMIT_WAIT:
            begin
                if (m_tready)
                begin
                    if (sts.out_last)
                    begin
                        // Frame done: empty the store
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/dis_datapath.sv
// Datapath for the descending insertion sorter: value store, insertion
// pointer, counters and output register. Depends on dis_pkg.
`default_nettype none

module dis_datapath
    import dis_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [VALUE_W-1:0]          s_tdata,
    input  wire                         s_tlast,
    input  wire                         m_tready,
    output logic                        m_tvalid,
    output logic [VALUE_W+DROP_W-1:0]   m_tdata,
    output logic                        m_tlast,
    input  dp_cmd_t                     cmd,
    output dp_sts_t                     sts
);

    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    // Value store
    logic [VALUE_W-1:0] mem [CAPACITY];

    logic [VALUE_W-1:0] key_reg;
    logic               last_reg;
    logic [ADDR_W-1:0]  pos_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [DROP_W-1:0]  drop_reg;
    logic [ADDR_W-1:0]  idx_reg;
    logic [VALUE_W-1:0] rd_data_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic               out_last_reg;
    logic               out_valid_reg;

    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [VALUE_W-1:0] wr_data;
    logic               emit_last;

    // Read address select
    always_comb
    begin
        case (cmd.rd_src)
            RD_POS_M1: rd_addr = pos_reg - ADDR_W'(1);
            RD_POS_M2: rd_addr = pos_reg - ADDR_W'(2);
            RD_EMIT:   rd_addr = idx_reg;
            default:   rd_addr = idx_reg;
        endcase
    end

    assign wr_en     = cmd.wr_shift | cmd.wr_key;
    assign wr_data   = cmd.wr_shift ? rd_data_reg : key_reg;
    assign emit_last = (CNT_W'(idx_reg) + CNT_W'(1)) == count_reg;

    // Store write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pos_reg] <= wr_data;
        end
    end

    // Store read port
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Incoming key
    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= s_tdata;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= emit_last;
        end
    end

    // Control registers: pointers, counts, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg      <= 1'b0;
            pos_reg       <= '0;
            count_reg     <= '0;
            drop_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load_key)
            begin
                last_reg <= s_tlast;
                pos_reg  <= count_reg[ADDR_W-1:0];
            end
            else if (cmd.wr_shift)
            begin
                pos_reg <= pos_reg - ADDR_W'(1);
            end

            if (cmd.clear)
            begin
                count_reg <= '0;
                drop_reg  <= '0;
                idx_reg   <= '0;
            end
            else
            begin
                if (cmd.wr_key)
                begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                // Saturate the drop count
                if (cmd.drop_inc && (drop_reg != {DROP_W{1'b1}}))
                begin
                    drop_reg <= drop_reg + DROP_W'(1);
                end
                if (cmd.out_load)
                begin
                    idx_reg <= idx_reg + ADDR_W'(1);
                end
            end

            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Status to controller
    assign sts.full       = (count_reg == CNT_W'(CAPACITY));
    assign sts.pos_zero   = (pos_reg == '0);
    assign sts.pos_one    = (pos_reg == ADDR_W'(1));
    assign sts.shift_more = ($signed(rd_data_reg) < $signed(key_reg));
    assign sts.last_item  = last_reg;
    assign sts.out_last   = out_last_reg;

    // Output beat
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {drop_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

### design/descending_insertion_sorter.sv
// Top level of the descending insertion sorter.
// Instantiates dis_ctrl and dis_datapath; depends on dis_pkg.
//
// Collects signed 32-bit values into a store of CAPACITY entries, kept in
// descending order as they arrive: each accepted value walks up from the
// tail of the store, moving every smaller entry down one slot, one entry per
// cycle through the single read and single write port of the store. A value
// that finds the store full is dropped and counted in a saturating 8-bit
// drop count. An item with tlast set ends the frame: after its insertion or
// drop the whole store is sent out, largest first. Each beat is read from the
// store, loaded into the output register and held until the sink takes it,
// and only then is the next one fetched. The final beat is marked with m_tlast
// and every beat carries the frame's drop count. The store and the drop count
// are then empty again. No input beat is taken while a frame is being sent.
// The store is not cleared at reset; only written entries are ever read.
`default_nettype none

module descending_insertion_sorter
    import dis_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [VALUE_W-1:0]          s_tdata,   // [31:0] value
    input  wire                         s_tlast,
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [VALUE_W+DROP_W-1:0]   m_tdata,   // [31:0] sorted_value, [39:32] dropped
    output logic                        m_tlast
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    // Sequencer
    dis_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Store, counters and output register
    dis_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cmd      (cmd),
        .sts      (sts)
    );

endmodule

`default_nettype wire

### design/dis_checker.sv
// Port-level checker for the descending insertion sorter, bound to the top level.
// Depends on dis_pkg.
`default_nettype none

module dis_checker
    import dis_pkg::*;
(
    input wire                       clk,
    input wire                       rst_n,
    input wire                       s_tready,
    input wire                       m_tvalid,
    input wire                       m_tready,
    input wire [VALUE_W+DROP_W-1:0]  m_tdata,
    input wire                       m_tlast
);

    // Stalled output beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output beat changed while stalled");

    // No intake while a frame is being sent
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while output beat pending");

    // Intake resumes right after the last beat of a frame
    a_resume: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not ready after end of frame");

    // A taken beat that is not the last is followed by a fetch gap
    a_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> (!m_tvalid && !s_tready))
        else $error("unexpected state after a mid-frame beat");

endmodule

bind descending_insertion_sorter dis_checker u_dis_checker (.*);

`default_nettype wire
